FILE: rtl/core/bat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint address table package
// Widths, request codes and the beat and cell interface types shared by the
// table and its cells.
// ----------------------------------------------------------------------------
package bat_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);

   localparam int REQ_TYPE_W    = 3;
   localparam int ADDR_W        = 16;
   localparam int ENTRY_INDEX_W = 8;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD    = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 3'd4;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]    req_type;
      logic [ADDR_W-1:0]        bp_address;
      logic [ENTRY_INDEX_W-1:0] entry_index;
   } bat_req_type;

   typedef struct packed {
      logic                     hit;
      logic [ADDR_W-1:0]        entry_value;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     add_dropped;
   } bat_rsp_type;

   typedef struct packed {
      logic valid;
      logic write;
      logic read_sel;
      logic start;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic [ADDR_W-1:0] value;
      logic [ADDR_W-1:0] read_data;
      logic              match;
      logic              hole;
   } cell_stat_type;

endpackage

FILE: rtl/core/bat_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint table cell
// Holds one stored address, compares it with the request address and, while
// a delete closes its gap, takes the value of its right-hand neighbor and
// passes the hole on to it.
// ----------------------------------------------------------------------------
module bat_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  bat_pkg::cell_ctl_type       ctl,
   input  logic [bat_pkg::ADDR_W-1:0]  bp_address,
   input  logic                        hole_left,
   input  logic [bat_pkg::ADDR_W-1:0]  right_value,
   output bat_pkg::cell_stat_type      stat
);
   import bat_pkg::*;

   logic [ADDR_W-1:0] value_ff;
   logic [ADDR_W-1:0] value_in;
   logic              hole_ff;
   logic              hole_in;
   logic              match;

   assign match = ctl.valid & (value_ff == bp_address);

   always_comb begin
      value_in = value_ff;
      if (ctl.shift & hole_ff) begin
         value_in = right_value;
      end else if (ctl.write) begin
         value_in = bp_address;
      end
   end

   always_comb begin
      if (ctl.start) begin
         hole_in = match;
      end else begin
         hole_in = ctl.shift & hole_left;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hole_ff <= 1'b0;
      end else begin
         hole_ff <= hole_in;
      end
   end

   assign stat.value     = value_ff;
   assign stat.read_data = (ctl.valid & ctl.read_sel) ? value_ff : '0;
   assign stat.match     = match;
   assign stat.hole      = hole_ff;

endmodule

FILE: rtl/core/breakpoint_address_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint address table
// An insertion-ordered set of unique breakpoint addresses held in a row of
// cells, with lookup, add, delete, indexed read and clear requests.
// ----------------------------------------------------------------------------
// Every request beat gives one response beat, registered and shown in the
// cycle after the request is taken. Lookup, add, read and clear requests
// leave the table idle, so a new request can be taken in every cycle while
// the response side keeps up. A delete that finds its address answers at
// once, but then closes the gap by moving a hole up the row of cells one
// cell per cycle, and req_stall stays high until the hole has left the
// filled cells. A delete that misses is handled like any other request.
module breakpoint_address_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bat_pkg::bat_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bat_pkg::bat_rsp_type rsp_data
);
   import bat_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SHIFT = 2'b10
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   bat_rsp_type          rsp_data_ff;
   bat_rsp_type          rsp_data_in;

   cell_ctl_type         ctl [TABLE_ENTRIES];
   cell_stat_type        stat [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] hole_vec;

   logic                 req_accept;
   logic                 any_hit;
   logic                 hole_active;
   logic [ADDR_W-1:0]    read_value;
   logic                 is_lookup;
   logic                 is_add;
   logic                 is_delete;
   logic                 is_read;
   logic                 is_clear;
   logic                 not_full;
   logic                 add_new;
   logic                 add_drop;
   logic                 del_hit;

   assign req_stall  = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;

   assign is_lookup = (req_data.req_type == REQ_LOOKUP);
   assign is_add    = (req_data.req_type == REQ_ADD);
   assign is_delete = (req_data.req_type == REQ_DELETE);
   assign is_read   = (req_data.req_type == REQ_READ);
   assign is_clear  = (req_data.req_type == REQ_CLEAR);

   assign not_full = (count_ff < COUNT_W'(TABLE_ENTRIES));
   assign add_new  = req_accept & is_add & ~any_hit & not_full;
   assign add_drop = is_add & ~any_hit & ~not_full;
   assign del_hit  = req_accept & is_delete & any_hit;

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      logic              hole_left;
      logic [ADDR_W-1:0] right_value;

      assign ctl[k].valid    = (count_ff > COUNT_W'(k));
      assign ctl[k].write    = add_new & (count_ff == COUNT_W'(k));
      assign ctl[k].read_sel = (req_data.entry_index == ENTRY_INDEX_W'(k));
      assign ctl[k].start    = del_hit;
      assign ctl[k].shift    = (state_ff == ST_SHIFT);

      if (k == 0) begin : g_first
         assign hole_left = 1'b0;
      end else begin : g_inner
         assign hole_left = stat[k-1].hole;
      end

      if (k == TABLE_ENTRIES - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_next
         assign right_value = stat[k+1].value;
      end

      assign hole_vec[k] = stat[k].hole;

      bat_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl[k]),
         .bp_address  (req_data.bp_address),
         .hole_left   (hole_left),
         .right_value (right_value),
         .stat        (stat[k])
      );
   end

   always_comb begin
      any_hit     = 1'b0;
      hole_active = 1'b0;
      read_value  = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         any_hit     = any_hit | stat[i].match;
         hole_active = hole_active | (stat[i].hole & ctl[i].valid);
         read_value  = read_value | stat[i].read_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_accept) begin
         if (is_clear) begin
            count_in = '0;
         end else if (add_new) begin
            count_in = count_ff + 1'b1;
         end else if (del_hit) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (del_hit) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (!hole_active) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_data_in.hit         = (is_lookup | is_add | is_delete) & any_hit;
      rsp_data_in.entry_value = is_read ? read_value : '0;
      rsp_data_in.entry_count = ENTRY_COUNT_W'(count_in);
      rsp_data_in.add_dropped = add_drop;
   end

   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_ENTRIES))
      else $error("entry count exceeds table capacity");

   a_single_hole : assert property (@(posedge clock) disable iff (reset)
      $onehot0(hole_vec))
      else $error("more than one hole in the cell row");

   a_shift_blocks : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (req_stall && !req_accept))
      else $error("request taken while a delete is closing its gap");

   a_delete_count : assert property (@(posedge clock) disable iff (reset)
      del_hit |=> (count_ff == COUNT_W'($past(count_ff) - 1'b1)))
      else $error("delete hit did not lower the count by one");

   a_add_count : assert property (@(posedge clock) disable iff (reset)
      add_new |=> (count_ff == COUNT_W'($past(count_ff) + 1'b1)))
      else $error("add of a new address did not raise the count by one");

endmodule

FILE: dv/tb_breakpoint_address_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breakpoint address table testbench
// Drives lookup, add, delete, indexed read, clear and undefined requests into
// the table with random gaps and response stalls. A shadow copy of the table
// predicts every response beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_breakpoint_address_table;

   import bat_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_BEATS  = 1520;
   localparam int ADDR_POOL     = 24;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AT_BEAT  = 100;
   localparam int DRAIN_CYCLES  = 24;
   localparam int CYCLE_LIMIT   = 400000;

   class bat_scoreboard;
      logic [ADDR_W-1:0] shadow_table [TABLE_ENTRIES];
      int                shadow_count = 0;
      bat_rsp_type       table_answers [$];
      int                failures = 0;

      function void note_request(bat_req_type req);
         bat_rsp_type answer;
         int          pos;
         answer = '0;
         pos = shadow_count;
         for (int k = shadow_count - 1; k >= 0; k--) begin
            if (shadow_table[k] == req.bp_address) pos = k;
         end
         case (req.req_type)
            REQ_LOOKUP: begin
               answer.hit = (pos < shadow_count);
            end
            REQ_ADD: begin
               if (pos < shadow_count) begin
                  answer.hit = 1'b1;
               end else if (shadow_count >= TABLE_ENTRIES) begin
                  answer.add_dropped = 1'b1;
               end else begin
                  shadow_table[shadow_count] = req.bp_address;
                  shadow_count++;
               end
            end
            REQ_DELETE: begin
               if (pos < shadow_count) begin
                  answer.hit = 1'b1;
                  for (int k = pos; k + 1 < shadow_count; k++) begin
                     shadow_table[k] = shadow_table[k + 1];
                  end
                  shadow_count--;
               end
            end
            REQ_READ: begin
               if (int'(req.entry_index) < shadow_count) begin
                  answer.entry_value = shadow_table[req.entry_index];
               end
            end
            REQ_CLEAR: begin
               shadow_count = 0;
            end
            default: begin
            end
         endcase
         answer.entry_count = ENTRY_COUNT_W'(shadow_count);
         table_answers.push_back(answer);
      endfunction

      function void check_response(bat_rsp_type rsp);
         bat_rsp_type want;
         if (table_answers.size() == 0) begin
            $error("response beat with no request outstanding: %h", rsp);
            failures++;
            return;
         end
         want = table_answers.pop_front();
         if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
            failures++;
         end
         if (rsp.entry_value !== want.entry_value) begin
            $error("entry_value: expected %h, actual %h", want.entry_value, rsp.entry_value);
            failures++;
         end
         if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, rsp.entry_count);
            failures++;
         end
         if (rsp.add_dropped !== want.add_dropped) begin
            $error("add_dropped: expected %0d, actual %0d", want.add_dropped,
                   rsp.add_dropped);
            failures++;
         end
      endfunction

      function int outstanding();
         return table_answers.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bat_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bat_rsp_type rsp_data;

   bat_scoreboard     sb;
   logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
   bit                sender_quiet = 1'b0;
   int                cycle_count = 0;

   breakpoint_address_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_breakpoint_address_table NOT OK");
         $finish;
      end
   end

   function automatic bat_req_type make_req(logic [REQ_TYPE_W-1:0] kind,
                                            logic [ADDR_W-1:0] addr,
                                            logic [ENTRY_INDEX_W-1:0] index);
      bat_req_type req;
      req.req_type    = kind;
      req.bp_address  = addr;
      req.entry_index = index;
      return req;
   endfunction

   function automatic bat_req_type random_req();
      bat_req_type req;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 34) req.req_type = REQ_ADD;
      else if (pick < 54) req.req_type = REQ_DELETE;
      else if (pick < 74) req.req_type = REQ_LOOKUP;
      else if (pick < 94) req.req_type = REQ_READ;
      else if (pick < 97) req.req_type = REQ_CLEAR;
      else req.req_type = REQ_TYPE_W'($urandom_range(5, 7));
      if ($urandom_range(0, 4) != 0) req.bp_address = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
      else req.bp_address = ADDR_W'($urandom);
      if ($urandom_range(0, 6) != 0) req.entry_index = ENTRY_INDEX_W'($urandom_range(0, 17));
      else req.entry_index = ENTRY_INDEX_W'($urandom_range(0, 255));
      return req;
   endfunction

   task automatic send_request(bat_req_type req);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_stall);
      sb.note_request(req);
   endtask

   task automatic take_responses();
      int  hold;
      int  beats;
      bit  quiet;
      beats = 0;
      quiet = 1'b0;
      forever begin
         if (beats % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         hold = quiet ? 0 : $urandom_range(0, 14);
         if (beats == HOLD_AT_BEAT) hold = LONG_HOLD;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
         beats++;
      end
   endtask

   initial begin
      sb = new;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int k = 2; k < ADDR_POOL; k++) addr_pool[k] = ADDR_W'($urandom);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         take_responses();
      join_none

      send_request(make_req(REQ_LOOKUP, 16'h1234, 8'd0));
      send_request(make_req(REQ_ADD, 16'h0000, 8'd255));
      send_request(make_req(REQ_ADD, 16'hFFFF, 8'd0));
      send_request(make_req(REQ_ADD, 16'hFFFF, 8'd0));
      send_request(make_req(REQ_READ, 16'hFFFF, 8'd255));
      send_request(make_req(REQ_DELETE, 16'h1234, 8'd0));
      send_request(make_req(REQ_DELETE, 16'h0000, 8'd0));
      for (int k = 0; k < TABLE_ENTRIES - 1; k++) begin
         send_request(make_req(REQ_ADD, ADDR_W'(16'h8001 + 16'h0101 * k), 8'd0));
      end
      send_request(make_req(REQ_ADD, 16'h5AA5, 8'd0));
      send_request(make_req(REQ_ADD, 16'hFFFF, 8'd0));
      send_request(make_req(REQ_DELETE, 16'hFFFF, 8'd0));
      send_request(make_req(REQ_READ, 16'h0000, 8'd14));
      send_request(make_req(REQ_READ, 16'h0000, 8'd15));
      send_request(make_req(REQ_CLEAR, 16'hFFFF, 8'd255));
      send_request(make_req(3'd5, 16'hFFFF, 8'd255));
      send_request(make_req(3'd6, 16'h0000, 8'd0));
      send_request(make_req(3'd7, 16'hFFFF, 8'd255));

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 64 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
         send_request(random_req());
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("tb_breakpoint_address_table OK");
      end else begin
         $display("tb_breakpoint_address_table NOT OK");
      end
      $finish;
   end

endmodule
